/* design/fpll_pkg.sv */
// Package for the four-pole ladder low-pass filter: fixed-point constants
// and the rounding and saturation helpers.
// No dependencies; used by the top level and the cutoff normaliser.
package fpll_pkg;

  localparam int SAMPLE_RATE_DEF = 48000;

  // Q4.28 constants, round(c * 2^28)
  localparam logic signed [32:0] K_TUNE = 33'sd311385129;  // 1.16
  localparam logic signed [32:0] K_DAMP = 33'sd40265318;   // 0.15
  localparam logic signed [32:0] K_GAIN = 33'sd93987306;   // 0.35013
  localparam logic signed [32:0] K_ZERO = 33'sd80530637;   // 0.3

  // cutoff smoothing, 0.05 in Q0.16 and its complement
  localparam logic signed [32:0] K_SMOOTH   = 33'sd3277;
  localparam logic signed [32:0] K_SMOOTH_C = 33'sd62259;

  localparam logic signed [65:0] QONE_W = 66'sd268435456;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Q4.28 product: round half up, drop 28 fraction bits, saturate
  function automatic logic signed [31:0] qpost(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd134217728) >>> 28;
    return sat32(t);
  endfunction

  // Q2.14 by Q4.28 product back to Q4.28
  function automatic logic signed [31:0] fbpost(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd8192) >>> 14;
    return sat32(t);
  endfunction

endpackage

/* design/fpll_if.sv */
// Handshake channels of the ladder filter: one for input items, one for results.
// Depends on nothing; the payload widths are fixed by the block.
interface fpll_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_in;
  logic        [14:0] cutoff_hz;
  logic        [15:0] resonance;

  modport source (output valid, sample_in, cutoff_hz, resonance, input ready);
  modport sink   (input valid, sample_in, cutoff_hz, resonance, output ready);
endinterface

interface fpll_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

/* design/fpll_mul.sv */
// Shared signed 33x33 multiplier of the ladder filter, product registered.
// No package dependencies.
module fpll_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

/* design/fpll_div.sv */
// Quotient correction of the cutoff normalisation fc = (co << 13) / SAMPLE_RATE.
// Takes the reciprocal estimate and its back-product from the shared multiplier.
// Uses fpll_pkg for the default sample rate.
module fpll_div #(
  parameter int SAMPLE_RATE = fpll_pkg::SAMPLE_RATE_DEF
) (
  input  logic        [31:0] co,
  input  logic signed [31:0] est,
  input  logic signed [65:0] back,
  output logic signed [31:0] quot
);

  localparam logic signed [65:0] RATE_W = 66'(SAMPLE_RATE);

  logic signed [65:0] num;
  logic signed [65:0] rem;

  // estimate is never high and at most one low, so one compare and subtract
  assign num  = $signed({21'b0, co, 13'b0});
  assign rem  = num - back;
  assign quot = (rem >= RATE_W) ? (est + 32'sd1) : est;

endmodule

/* design/four_pole_ladder_lowpass.sv */
// Top level of the resonant four-pole ladder low-pass filter.
// Uses fpll_pkg, the channels of fpll_if, fpll_mul and fpll_div.
//
// One item in, one item out. An accepted item runs through a small sequencer
// around one shared 33x33 multiplier: each of the 20 products passes through
// ST_MUL and ST_WB (operand select and multiply, then round, saturate and
// write back). The cutoff normalisation is two of those products: a multiply
// by the reciprocal of the sample rate, then a back-multiply whose remainder
// decides a one-step correction of the quotient. The input side takes no new
// item until the result of the last one is in the output register, since all
// products share the single multiplier. The output register lets the next
// item start while a result still waits to be taken; a result left waiting
// holds the next item at its last step. Reset clears the smoothed cutoff and
// all pole state at once; no clearing pass is needed.
module four_pole_ladder_lowpass #(
  parameter int SAMPLE_RATE = fpll_pkg::SAMPLE_RATE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fpll_in_if.sink           samples,
  fpll_out_if.source        filtered
);

  localparam int HALF_RATE = SAMPLE_RATE / 2;

  // 2^44 / rate, truncated; with a cutoff below 2^31 the estimate is short by
  // at most one
  localparam logic signed [32:0] RECIP  = 33'((64'd1 << 44) / 64'(SAMPLE_RATE));
  localparam logic signed [32:0] RATE_M = 33'(SAMPLE_RATE);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_WB   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // one code per kind of product; SP_ZERO and SP_POLE repeat for each pole
  typedef enum logic [3:0] {
    SP_CO_A,  // smoothed cutoff times (1 - 0.05)
    SP_CO_B,  // new cutoff times 0.05
    SP_RCP,   // fc estimate: cutoff times reciprocal of the rate
    SP_CHK,   // estimate times rate, remainder corrects fc
    SP_TUNE,  // f = 1.16 * fc
    SP_F2,    // f^2
    SP_DAMP,  // 1 - 0.15 f^2
    SP_FB,    // feedback = res * damping
    SP_F4,    // f^4
    SP_GAIN,  // 0.35013 f^4
    SP_FBK,   // input minus feedback of last output
    SP_XG,    // scale by gain
    SP_ZERO,  // 0.3 * pole input
    SP_POLE   // (1 - f) * pole output, then the pole sum
  } step_t;

  state_t state;
  step_t  step;
  logic [1:0] k;          // pole index

  // filter state
  logic        [31:0] sc;
  logic signed [31:0] pi [4];
  logic signed [31:0] po [4];

  // item registers and intermediates
  logic signed [23:0] smp_r;
  logic        [14:0] cut_r;
  logic        [15:0] res_r;
  logic        [31:0] co_part;
  logic signed [31:0] fc, f, f2, fb, g, omf, x, tmp;
  logic signed [31:0] fc_fix;

  // output register
  logic               out_valid;
  logic signed [23:0] out_data;
  logic               out_load;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [31:0] qm;

  logic [65:0]        co_rnd;
  logic [31:0]        co_new;
  logic signed [65:0] pole_sum;
  logic signed [32:0] y_rnd;
  logic signed [32:0] y_sh;
  logic signed [23:0] y_sat;

  fpll_mul u_mul (
    .clk (clk),
    .en  (state == ST_MUL),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  fpll_div #(.SAMPLE_RATE(SAMPLE_RATE)) u_div (
    .co   (sc),
    .est  (fc),
    .back (prod),
    .quot (fc_fix)
  );

  // operand selection for the current step
  always_comb begin
    case (step)
      SP_CO_A: begin
        ma = $signed({1'b0, sc});
        mb = fpll_pkg::K_SMOOTH_C;
      end
      SP_CO_B: begin
        ma = $signed({18'b0, cut_r});
        mb = fpll_pkg::K_SMOOTH;
      end
      SP_RCP: begin
        ma = $signed({1'b0, sc});
        mb = RECIP;
      end
      SP_CHK: begin
        ma = 33'(fc);
        mb = RATE_M;
      end
      SP_TUNE: begin
        ma = 33'(fc);
        mb = fpll_pkg::K_TUNE;
      end
      SP_F2: begin
        ma = 33'(f);
        mb = 33'(f);
      end
      SP_DAMP: begin
        ma = fpll_pkg::K_DAMP;
        mb = 33'(f2);
      end
      SP_FB: begin
        ma = $signed({17'b0, res_r});
        mb = 33'(tmp);
      end
      SP_F4: begin
        ma = 33'(f2);
        mb = 33'(f2);
      end
      SP_GAIN: begin
        ma = 33'(tmp);
        mb = fpll_pkg::K_GAIN;
      end
      SP_FBK: begin
        ma = 33'(po[3]);
        mb = 33'(fb);
      end
      SP_XG: begin
        ma = 33'(x);
        mb = 33'(g);
      end
      SP_ZERO: begin
        ma = fpll_pkg::K_ZERO;
        mb = 33'(pi[k]);
      end
      SP_POLE: begin
        ma = 33'(omf);
        mb = 33'(po[k]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // write-back arithmetic on the registered product
  always_comb begin
    qm       = fpll_pkg::qpost(prod);
    co_rnd   = (prod + 66'sd32768) >>> 16;
    co_new   = prod[31:0] + co_part;
    pole_sum = 66'(x) + 66'(tmp) + 66'(qm);
  end

  // last pole output back to Q1.23, rounded half up and saturated
  always_comb begin
    y_rnd = 33'(po[3]) + 33'sd16;
    y_sh  = y_rnd >>> 5;
    if (y_sh > 33'sd8388607) begin
      y_sat = 24'h7F_FFFF;
    end else if (y_sh < -33'sd8388608) begin
      y_sat = 24'h80_0000;
    end else begin
      y_sat = y_sh[23:0];
    end
  end

  // result goes into the output register once it is free or being emptied
  assign out_load = (state == ST_OUT) && (!out_valid || filtered.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= SP_CO_A;
      k         <= '0;
      out_valid <= 1'b0;
      sc        <= '0;
      for (int i = 0; i < 4; i++) begin
        pi[i] <= '0;
        po[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && filtered.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            smp_r <= samples.sample_in;
            res_r <= samples.resonance;
            // cutoff above half rate is held at half rate
            if (32'(samples.cutoff_hz) > 32'(HALF_RATE)) begin
              cut_r <= 15'(HALF_RATE);
            end else begin
              cut_r <= samples.cutoff_hz;
            end
            step  <= SP_CO_A;
            k     <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_WB;
        end
        ST_WB: begin
          state <= ST_MUL;
          case (step)
            SP_CO_A: begin
              co_part <= co_rnd[31:0];
              step    <= SP_CO_B;
            end
            SP_CO_B: begin
              sc   <= co_new;
              step <= SP_RCP;
            end
            SP_RCP: begin
              fc   <= prod[62:31];
              step <= SP_CHK;
            end
            SP_CHK: begin
              fc   <= fc_fix;
              step <= SP_TUNE;
            end
            SP_TUNE: begin
              f    <= qm;
              step <= SP_F2;
            end
            SP_F2: begin
              f2   <= qm;
              omf  <= fpll_pkg::sat32(fpll_pkg::QONE_W - 66'(f));
              step <= SP_DAMP;
            end
            SP_DAMP: begin
              tmp  <= fpll_pkg::sat32(fpll_pkg::QONE_W - 66'(qm));
              step <= SP_FB;
            end
            SP_FB: begin
              fb   <= fpll_pkg::fbpost(prod);
              step <= SP_F4;
            end
            SP_F4: begin
              tmp  <= qm;
              step <= SP_GAIN;
            end
            SP_GAIN: begin
              g    <= qm;
              step <= SP_FBK;
            end
            SP_FBK: begin
              x    <= fpll_pkg::sat32((66'(smp_r) <<< 5) - 66'(qm));
              step <= SP_XG;
            end
            SP_XG: begin
              x    <= qm;
              step <= SP_ZERO;
            end
            SP_ZERO: begin
              tmp  <= qm;
              step <= SP_POLE;
            end
            SP_POLE: begin
              pi[k] <= x;
              po[k] <= fpll_pkg::sat32(pole_sum);
              x     <= fpll_pkg::sat32(pole_sum);
              if (k == 2'd3) begin
                state <= ST_OUT;
              end else begin
                k    <= k + 1'b1;
                step <= SP_ZERO;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_OUT: begin
          // wait for the output register to be free
          if (out_load) begin
            out_data <= y_sat;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign samples.ready       = (state == ST_IDLE);
  assign filtered.valid      = out_valid;
  assign filtered.sample_out = out_data;

endmodule

/* design/fpll_checker.sv */
// Port-level checks for the ladder filter, bound to the top level.
// Depends on the top level four_pole_ladder_lowpass and its channels.
module fpll_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_data
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed or dropped while stalled");

  // the block is busy right after it takes an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an item was taken");

  // no result can appear in the cycle after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind four_pole_ladder_lowpass fpll_checker u_fpll_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (filtered.valid),
  .out_ready (filtered.ready),
  .out_data  (filtered.sample_out)
);

/* dv/tb_four_pole_ladder_lowpass.sv */
// Self-checking testbench for the four-pole ladder low-pass filter: a bit-exact predictor
// of the fixed-point filter, a queue-fed driver and a checking monitor under varied idling.
// Depends on the channel interfaces of fpll_if and four_pole_ladder_lowpass, which uses fpll_pkg.
module tb_four_pole_ladder_lowpass;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_RATE = 48000;

  // Q4.28 figures of the filter, round(c * 2^28), plus the Q0.16 smoothing weight
  localparam longint Q_ONE    = 64'sd268435456;
  localparam longint Q_HALF   = 64'sd134217728;
  localparam longint TUNE_Q   = 64'sd311385129;  // 1.16
  localparam longint DAMP_Q   = 64'sd40265318;   // 0.15
  localparam longint GAIN_Q   = 64'sd93987306;   // 0.35013
  localparam longint ZERO_Q   = 64'sd80530637;   // 0.3
  localparam longint SMOOTH_W = 64'sd3277;       // 0.05 in Q0.16

  localparam int TIMEOUT_NS = 5000000;
  localparam int TAIL_CYCLES = 120;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [23:0] sample;
    logic        [14:0] cutoff;
    logic        [15:0] res;
  } ladder_item_t;

  typedef enum int {
    PH_FLOWING,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } idle_phase_e;

  logic clk;
  logic rst;

  fpll_in_if  samples_ch ();
  fpll_out_if filtered_ch ();

  four_pole_ladder_lowpass #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .filtered(filtered_ch)
  );

  // Stimulus waiting to be offered, and filtered samples still owed by the block
  ladder_item_t       pending_items[$];
  logic signed [23:0] filtered_due[$];

  // Predictor state: smoothed cutoff in Q16.16 Hz, pole memories in Q4.28
  logic        [31:0] smoothed_hz;
  logic signed [31:0] pole_in[4];
  logic signed [31:0] pole_out[4];

  int send_idle_pct;
  int recv_stall_pct;
  int n_results;
  int n_fail;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Q4.28 product; >>> on a signed longint floors, which gives round half up
  function automatic logic signed [31:0] qprod(input longint a, input longint b);
    return clip32((a * b + Q_HALF) >>> 28);
  endfunction

  // One filter step: advances the predictor state, returns the Q1.23 output
  function automatic logic signed [23:0] ladder_step(input ladder_item_t it);
    longint cut, co, smp, y;
    logic signed [31:0] fc, f, f2, damp, fb, g, x, nx, one_minus_f;
    cut = longint'(it.cutoff);
    smp = longint'(it.sample);
    // cutoff above half the sample rate is clamped before smoothing
    if (cut > SAMPLE_RATE / 2) begin
      cut = SAMPLE_RATE / 2;
    end
    co = ((cut <<< 16) * SMOOTH_W + longint'({32'b0, smoothed_hz}) * (65536 - SMOOTH_W)
          + 32768) >>> 16;
    smoothed_hz = co[31:0];

    fc   = clip32((longint'({32'b0, smoothed_hz}) <<< 13) / SAMPLE_RATE);
    f    = qprod(fc, TUNE_Q);
    f2   = qprod(f, f);
    damp = clip32(Q_ONE - longint'(qprod(DAMP_Q, f2)));
    fb   = clip32((longint'(it.res) * longint'(damp) + 8192) >>> 14);
    g    = qprod(qprod(f2, f2), GAIN_Q);

    // input less the resonance feedback, lifted from Q1.23 to Q4.28
    x = clip32(smp * 32 - longint'(qprod(pole_out[3], fb)));
    x = qprod(x, g);

    // runaway resonance ends in saturation of each pole, never wrap-around
    one_minus_f = clip32(Q_ONE - longint'(f));
    for (int k = 0; k < 4; k++) begin
      nx = clip32(longint'(x) + longint'(qprod(ZERO_Q, pole_in[k]))
                  + longint'(qprod(one_minus_f, pole_out[k])));
      pole_in[k]  = x;
      pole_out[k] = nx;
      x = nx;
    end

    // back to Q1.23, rounded half up, then clamped to 24 bits
    y = (longint'(pole_out[3]) + 16) >>> 5;
    if (y > 64'sd8388607) begin
      y = 64'sd8388607;
    end else if (y < -64'sd8388608) begin
      y = -64'sd8388608;
    end
    return y[23:0];
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  task automatic add_item(input int smp, input int cut, input int res);
    ladder_item_t it;
    it.sample = 24'(smp);
    it.cutoff = 15'(cut);
    it.res    = 16'(res);
    pending_items.push_back(it);
  endtask

  // Runs of items sharing a cutoff target and resonance, so that the smoothing
  // settles and the poles build up; the waveform is noise, a square wave of random
  // period and amplitude, or quiet signal. Now and then the cutoff jumps at random.
  task automatic queue_program(input int n);
    int left, seg, style, period, amp;
    int cut, res;
    ladder_item_t it;
    left = n;
    while (left > 0) begin
      seg = $urandom_range(24, 4);
      if (seg > left) begin
        seg = left;
      end
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(32767, 24001);
      end else begin
        cut = $urandom_range(24000, 0);
      end
      case ($urandom_range(3))
        0:       res = $urandom_range(65535, 0);
        1:       res = $urandom_range(65535, 49152);
        2:       res = $urandom_range(16383, 0);
        default: res = 65535;
      endcase
      style  = $urandom_range(2);
      period = $urandom_range(12, 1);
      amp    = $urandom_range(8388607, 1);
      for (int k = 0; k < seg; k++) begin
        case (style)
          0:       it.sample = 24'($urandom);
          1:       it.sample = ((k / period) % 2 != 0) ? 24'(-amp) : 24'(amp);
          default: it.sample = 24'(int'($urandom_range(2047, 0)) - 1024);
        endcase
        it.cutoff = ($urandom_range(7) == 0) ? 15'($urandom) : 15'(cut);
        it.res    = 16'(res);
        pending_items.push_back(it);
      end
      left -= seg;
    end
  endtask

  // -------------------------------------------------------------------------
  // Clock, reset and idle mix
  // -------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Known values on every input of the block from time zero
  initial begin
    samples_ch.valid     = 1'b0;
    samples_ch.sample_in = '0;
    samples_ch.cutoff_hz = '0;
    samples_ch.resonance = '0;
    filtered_ch.ready    = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Driver: offers queued items; an item counts once valid and ready meet
  // -------------------------------------------------------------------------

  always @(posedge clk) begin
    ladder_item_t nxt;
    ladder_item_t taken;
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else begin
      if (samples_ch.valid && samples_ch.ready) begin
        taken.sample = samples_ch.sample_in;
        taken.cutoff = samples_ch.cutoff_hz;
        taken.res    = samples_ch.resonance;
        filtered_due.push_back(ladder_step(taken));
      end
      // free to change the offer only when nothing is held or it was just taken
      if (!samples_ch.valid || samples_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          samples_ch.sample_in <= nxt.sample;
          samples_ch.cutoff_hz <= nxt.cutoff;
          samples_ch.resonance <= nxt.res;
          samples_ch.valid     <= 1'b1;
        end else begin
          samples_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: takes filtered samples under random stall, checks against the predictor
  // -------------------------------------------------------------------------

  always @(posedge clk) begin
    logic signed [23:0] want;
    if (rst) begin
      filtered_ch.ready <= 1'b0;
    end else begin
      if (filtered_ch.valid && filtered_ch.ready) begin
        if (filtered_due.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_MAX) begin
            $display("result %0d arrived with none outstanding: got %0d",
                     n_results, filtered_ch.sample_out);
          end
        end else begin
          want = filtered_due.pop_front();
          if (filtered_ch.sample_out !== want) begin
            n_fail++;
            if (n_fail <= REPORT_MAX) begin
              $display("sample_out mismatch on result %0d: expected %0d, got %0d",
                       n_results, want, filtered_ch.sample_out);
            end
          end
        end
        n_results++;
      end
      filtered_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: directed items, then random programmes under each idle phase
  // -------------------------------------------------------------------------

  initial begin
    idle_phase_e ph;
    smoothed_hz    = '0;
    for (int k = 0; k < 4; k++) begin
      pole_in[k]  = '0;
      pole_out[k] = '0;
    end
    n_results      = 0;
    n_fail         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    @(negedge rst);

    // silence, then full-scale steps at the top of the band with no feedback
    add_item(0, 0, 0);
    add_item(8388607, 24000, 0);
    add_item(8388607, 24000, 0);
    add_item(8388607, 24000, 0);
    // cutoff field at its top: clamped to half the sample rate
    add_item(-8388608, 32767, 0);
    add_item(-8388608, 32767, 0);
    add_item(-8388608, 24001, 0);
    // full feedback on a full-scale square wave: poles run away and the
    // output has to saturate rather than wrap
    for (int k = 0; k < 8; k++) begin
      add_item((k % 2 != 0) ? -8388608 : 8388607, 32767, 65535);
    end
    // odd corners: tiny values, mid resonance, cutoff falling to zero
    add_item(-1, 1, 1);
    add_item(1, 16384, 32768);
    add_item(-8388608, 0, 65535);
    add_item(8388607, 0, 65535);
    add_item(0, 12000, 16384);
    add_item(4194304, 8191, 49151);

    for (int p = 0; p < 4; p++) begin
      ph = idle_phase_e'(p);
      case (ph)
        PH_FLOWING:        begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        PH_SENDER_IDLE:    begin send_idle_pct = 58; recv_stall_pct = 0;  end
        PH_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default:           begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      queue_program(120);
      // phase ends once every item is taken and every result has come back
      while (pending_items.size() > 0 || samples_ch.valid || filtered_due.size() > 0) begin
        @(posedge clk);
      end
    end

    // quiet tail: any stray result would show up here
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", filtered_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
design/fpll_pkg.sv
design/fpll_if.sv
design/fpll_mul.sv
design/fpll_div.sv
design/four_pole_ladder_lowpass.sv
design/fpll_checker.sv
dv/tb_four_pole_ladder_lowpass.sv
